// ===== hdl/attack_fade_envelope_macros.svh =====
// Assertion macros shared by the envelope RTL.
`ifndef ATTACK_FADE_ENVELOPE_MACROS_SVH
`define ATTACK_FADE_ENVELOPE_MACROS_SVH

// Same-cycle implication, reset masked.
`define AFE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masked.
`define AFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/afe_pkg.sv =====
// Shared types and constants for the attack/fade envelope.
`timescale 1ns / 1ps

package afe_pkg;

	localparam int unsigned DW         = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned DIV_STAGES = 16;
	localparam logic [15:0] LEVEL_FULL = 16'hFFFF;

	typedef enum logic [1:0] {
		PHASE_NONE   = 2'd0,
		PHASE_ATTACK = 2'd1,
		PHASE_FADE   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		REG_ATTACK_LENGTH      = 3'd0,
		REG_ATTACK_START_LEVEL = 3'd1,
		REG_FADE_LENGTH        = 3'd2,
		REG_FADE_END_LEVEL     = 3'd3,
		REG_EFFECT_DURATION    = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic signed [15:0] force_in;
		logic [15:0]        since_start_ms;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] force_out;
		phase_t             phase;
	} shaped_t;

endpackage

// ===== hdl/attack_fade_envelope.sv =====
// Attack/fade envelope shaper: pipelined top level with config registers.
`timescale 1ns / 1ps
`include "attack_fade_envelope_macros.svh"

// Shapes a signed force sample with an attack-and-fade envelope. During the
// attack window (since_start_ms below attack_length) the force ramps linearly
// from attack_start_level/65535 of itself up to full force; after that, once
// since_start_ms reaches effect_duration - fade_length, it ramps from full
// force down toward fade_end_level/65535 of itself, holding the end level past
// the duration. Fade is off when fade_length or effect_duration is zero or when
// fade_length exceeds effect_duration. All scaling truncates toward zero.
// Takes one item per clock while the skid buffer is empty. The 16-stage
// restoring divider turns elapsed time into ramp progress (one quotient bit
// per stage), with the phase, multiply and rescale stages around it. A
// one-entry skid buffer sits behind the output register, so the pipeline
// keeps moving through the first stalled cycle downstream. Config registers
// must be written through the plain write port while no item is in flight;
// the block itself does not enforce this.
module attack_fade_envelope (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [afe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [afe_pkg::DW-1:0]        cfg_wdata,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  afe_pkg::sample_t              sample,
	output logic                          shaped_valid,
	input  logic                          shaped_ready,
	output afe_pkg::shaped_t              shaped
);
	import afe_pkg::*;

	// Stage payloads
	typedef struct packed {
		phase_t             phase;
		logic               sat;        // fade progress pinned at full
		logic signed [15:0] force_v;
		logic [15:0]        ramp_pos;   // ms into the current ramp
		logic [15:0]        divisor;    // ramp length
		logic [15:0]        level;      // start or end fraction
	} s1_t;

	typedef struct packed {
		phase_t             phase;
		logic               sat;
		logic signed [15:0] force_v;
		logic [15:0]        divisor;
		logic [31:0]        num;        // ramp_pos * 65535
		logic [31:0]        prod;       // |force| * level
	} s2_t;

	typedef struct packed {
		phase_t             phase;
		logic               sat;
		logic signed [15:0] force_v;
		logic signed [16:0] scaled;     // force * level / 65535
		logic [15:0]        divisor;
		logic [15:0]        rem;
		logic [15:0]        nq;         // numerator bits in, quotient bits out
	} div_t;

	typedef struct packed {
		phase_t             phase;
		logic signed [15:0] force_v;
		logic signed [16:0] scaled;
		logic               diff_neg;
		logic [15:0]        diff_mag;
		logic [15:0]        progress;
	} sa_t;

	typedef struct packed {
		phase_t             phase;
		logic signed [15:0] force_v;
		logic signed [16:0] scaled;
		logic               diff_neg;
		logic [31:0]        prod;
	} sb_t;

	typedef struct packed {
		phase_t             phase;
		logic signed [15:0] force_v;
		logic signed [16:0] scaled;
		logic signed [16:0] delta;
	} sc_t;

	// m / 65535 for m below 2^31: one correction step on m >> 16
	function automatic logic [15:0] div_full(input logic [31:0] m);
		logic [15:0] q0;
		logic [16:0] r;
		q0 = m[31:16];
		r  = {1'b0, m[15:0]} + {1'b0, q0};
		return (r >= {1'b0, LEVEL_FULL}) ? q0 + 16'd1 : q0;
	endfunction

	// One restoring divide step
	function automatic div_t div_step(input div_t cur);
		logic [DW:0] trial;
		logic [DW:0] sub;
		div_t        nxt;
		trial = {cur.rem, cur.nq[DW-1]};
		sub   = trial - {1'b0, cur.divisor};
		nxt   = cur;
		if (trial >= {1'b0, cur.divisor}) begin
			nxt.rem = sub[DW-1:0];
			nxt.nq  = {cur.nq[DW-2:0], 1'b1};
		end else begin
			nxt.rem = trial[DW-1:0];
			nxt.nq  = {cur.nq[DW-2:0], 1'b0};
		end
		return nxt;
	endfunction

	// Config registers
	logic [15:0] attack_length_q;
	logic [15:0] attack_start_level_q;
	logic [15:0] fade_length_q;
	logic [15:0] fade_end_level_q;
	logic [15:0] effect_duration_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_length_q      <= '0;
			attack_start_level_q <= '0;
			fade_length_q        <= '0;
			fade_end_level_q     <= '0;
			effect_duration_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ATTACK_LENGTH:      attack_length_q      <= cfg_wdata;
				REG_ATTACK_START_LEVEL: attack_start_level_q <= cfg_wdata;
				REG_FADE_LENGTH:        fade_length_q        <= cfg_wdata;
				REG_FADE_END_LEVEL:     fade_end_level_q     <= cfg_wdata;
				REG_EFFECT_DURATION:    effect_duration_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Whole pipeline advances unless the skid buffer holds an item
	logic    en;
	logic    skid_v_q;
	logic    out_v_q;
	shaped_t out_q;
	shaped_t skid_q;

	assign en           = !skid_v_q;
	assign sample_ready = en;

	// Stage 1: phase decision, ramp distance and divisor
	s1_t         s1_n;
	s1_t         s1_s1;
	logic        v_s1;
	logic        in_attack;
	logic        fade_ok;
	logic        in_fade;
	logic [15:0] fade_start;
	logic [15:0] fade_pos;

	always_comb begin
		in_attack  = (attack_length_q != '0) && (sample.since_start_ms < attack_length_q);
		fade_ok    = (fade_length_q != '0) && (effect_duration_q != '0)
			&& (fade_length_q <= effect_duration_q);
		fade_start = effect_duration_q - fade_length_q;
		fade_pos   = sample.since_start_ms - fade_start;
		in_fade    = !in_attack && fade_ok && (sample.since_start_ms >= fade_start);

		s1_n.force_v = sample.force_in;
		// past the fade length the quotient would exceed full scale
		s1_n.sat     = in_fade && (fade_pos >= fade_length_q);
		if (in_attack) begin
			s1_n.phase    = PHASE_ATTACK;
			s1_n.ramp_pos = sample.since_start_ms;
			s1_n.divisor  = attack_length_q;
			s1_n.level    = attack_start_level_q;
		end else begin
			s1_n.phase    = in_fade ? PHASE_FADE : PHASE_NONE;
			s1_n.ramp_pos = fade_pos;
			s1_n.divisor  = fade_length_q;
			s1_n.level    = fade_end_level_q;
		end
	end

	// Stage 2: numerator and level product
	s2_t         s2_n;
	s2_t         s2_s2;
	logic        v_s2;
	logic [15:0] force_mag;

	always_comb begin
		force_mag     = s1_s1.force_v[15] ? 16'(-s1_s1.force_v) : 16'(s1_s1.force_v);
		s2_n.phase    = s1_s1.phase;
		s2_n.sat      = s1_s1.sat;
		s2_n.force_v  = s1_s1.force_v;
		s2_n.divisor  = s1_s1.divisor;
		s2_n.prod     = force_mag * s1_s1.level;
		// zeroed when unused so the divider invariant rem < divisor holds
		if (s1_s1.phase != PHASE_NONE && !s1_s1.sat) begin
			s2_n.num = {s1_s1.ramp_pos, 16'd0} - {16'd0, s1_s1.ramp_pos};
		end else begin
			s2_n.num = '0;
		end
	end

	// Divider entry: also rescales the level product
	div_t                  div_entry;
	div_t                  div_n [1:DIV_STAGES];
	div_t                  div_s [0:DIV_STAGES];
	logic [DIV_STAGES:0]   div_v_s;
	logic [15:0]           scaled_mag;

	always_comb begin
		scaled_mag          = div_full(s2_s2.prod);
		div_entry.phase     = s2_s2.phase;
		div_entry.sat       = s2_s2.sat;
		div_entry.force_v   = s2_s2.force_v;
		div_entry.divisor   = s2_s2.divisor;
		div_entry.rem       = s2_s2.num[31:16];
		div_entry.nq        = s2_s2.num[15:0];
		div_entry.scaled    = s2_s2.force_v[15] ? -$signed({1'b0, scaled_mag})
			: $signed({1'b0, scaled_mag});
	end

	always_comb begin
		for (int k = 1; k <= DIV_STAGES; k++) begin
			div_n[k] = div_step(div_s[k-1]);
		end
	end

	// Stage a: progress and distance from force to scaled level
	sa_t         sa_n;
	sa_t         sa_sa;
	logic        v_sa;
	logic [16:0] diff;
	logic [16:0] diff_inv;

	always_comb begin
		diff           = {div_s[DIV_STAGES].force_v[15], div_s[DIV_STAGES].force_v}
			- div_s[DIV_STAGES].scaled;
		diff_inv       = -diff;
		sa_n.phase     = div_s[DIV_STAGES].phase;
		sa_n.force_v   = div_s[DIV_STAGES].force_v;
		sa_n.scaled    = div_s[DIV_STAGES].scaled;
		sa_n.diff_neg  = diff[16];
		sa_n.diff_mag  = diff[16] ? diff_inv[15:0] : diff[15:0];
		sa_n.progress  = div_s[DIV_STAGES].sat ? LEVEL_FULL : div_s[DIV_STAGES].nq;
	end

	// Stage b: ramp product
	sb_t  sb_n;
	sb_t  sb_sb;
	logic v_sb;

	always_comb begin
		sb_n.phase    = sa_sa.phase;
		sb_n.force_v  = sa_sa.force_v;
		sb_n.scaled   = sa_sa.scaled;
		sb_n.diff_neg = sa_sa.diff_neg;
		sb_n.prod     = sa_sa.diff_mag * sa_sa.progress;
	end

	// Stage c: rescale ramp product, restore sign
	sc_t         sc_n;
	sc_t         sc_sc;
	logic        v_sc;
	logic [15:0] delta_mag;

	always_comb begin
		delta_mag     = div_full(sb_sb.prod);
		sc_n.phase    = sb_sb.phase;
		sc_n.force_v  = sb_sb.force_v;
		sc_n.scaled   = sb_sb.scaled;
		sc_n.delta    = sb_sb.diff_neg ? -$signed({1'b0, delta_mag})
			: $signed({1'b0, delta_mag});
	end

	// Final combine; result always lies between force and scaled level
	shaped_t            result_n;
	logic signed [16:0] res_wide;

	always_comb begin
		case (sc_sc.phase)
			PHASE_ATTACK: res_wide = sc_sc.scaled + sc_sc.delta;
			PHASE_FADE:   res_wide = {sc_sc.force_v[15], sc_sc.force_v} - sc_sc.delta;
			default:      res_wide = {sc_sc.force_v[15], sc_sc.force_v};
		endcase
		result_n.force_out = res_wide[15:0];
		result_n.phase     = sc_sc.phase;
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			div_v_s <= '0;
			v_sa    <= 1'b0;
			v_sb    <= 1'b0;
			v_sc    <= 1'b0;
		end else if (en) begin
			v_s1    <= sample_valid;
			v_s2    <= v_s1;
			div_v_s <= {div_v_s[DIV_STAGES-1:0], v_s2};
			v_sa    <= div_v_s[DIV_STAGES];
			v_sb    <= v_sa;
			v_sc    <= v_sb;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (en) begin
			s1_s1    <= s1_n;
			s2_s2    <= s2_n;
			div_s[0] <= div_entry;
			for (int k = 1; k <= DIV_STAGES; k++) begin
				div_s[k] <= div_n[k];
			end
			sa_sa    <= sa_n;
			sb_sb    <= sb_n;
			sc_sc    <= sc_n;
		end
	end

	// Output register and skid buffer
	logic take;

	assign take = shaped_ready || !out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= v_sc;
			end
		end else if (en && v_sc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_v_q ? skid_q : result_n;
		end
		if (!take && en && v_sc) begin
			skid_q <= result_n;
		end
	end

	assign shaped_valid = out_v_q;
	assign shaped       = out_q;

	// Checks
	`AFE_ASSERT_IMPL(a_skid_needs_out, clk, arst_n, skid_v_q, out_v_q, "skid item with empty output register")
	`AFE_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_v_q && shaped_ready, !skid_v_q, "skid item not moved to output")
	`AFE_ASSERT_IMPL(a_div_rem_bound, clk, arst_n, div_v_s[DIV_STAGES] && div_s[DIV_STAGES].phase != PHASE_NONE && !div_s[DIV_STAGES].sat, div_s[DIV_STAGES].rem < div_s[DIV_STAGES].divisor, "divider remainder out of range")
	`AFE_ASSERT_IMPL(a_attack_below_full, clk, arst_n, div_v_s[DIV_STAGES] && div_s[DIV_STAGES].phase == PHASE_ATTACK, div_s[DIV_STAGES].nq != LEVEL_FULL, "attack progress reached full scale")
	`AFE_ASSERT_IMPL(a_sat_only_fade, clk, arst_n, div_v_s[0] && div_s[0].sat, div_s[0].phase == PHASE_FADE, "saturated progress outside fade")

endmodule
